>>> rtl/core/moving_average_filter_defines.svh
// Assertion macros shared by the moving average filter RTL.
// Depends on nothing; included by files that carry assertions.
`ifndef MOVING_AVERAGE_FILTER_DEFINES_SVH
`define MOVING_AVERAGE_FILTER_DEFINES_SVH

// same-cycle implication, disabled in reset
`define MAF_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define MAF_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/maf_pkg.sv
// Package for the moving average filter: sizes, register map, divider port types.
// Depends on nothing.
`default_nettype none
package maf_pkg;

    localparam int WINDOW_MAX  = 256;
    localparam int SAMPLE_BITS = 16;

    localparam int ADDR_W = $clog2(WINDOW_MAX);     // ring index
    localparam int LEN_W  = ADDR_W + 1;             // holds WINDOW_MAX itself
    localparam int SUM_W  = SAMPLE_BITS + ADDR_W;   // exact sum of a full window
    localparam int CNT_W  = $clog2(SUM_W);          // divider step counter

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(8);
    localparam logic [LEN_W-1:0] LEN_MAX   = LEN_W'(WINDOW_MAX);

    // register index, taken from paddr[PADDR_W-1:2]
    localparam logic [PADDR_W-3:0] REG_WINDOW_LENGTH = '0;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    typedef struct packed {
        logic                    start;
        logic signed [SUM_W-1:0] dividend;
        logic [LEN_W-1:0]        divisor;
    } div_req_t;

    typedef struct packed {
        logic                          done;
        logic signed [SAMPLE_BITS-1:0] quotient;
    } div_rsp_t;

endpackage
`default_nettype wire

>>> rtl/core/maf_div.sv
// Radix-2 restoring divider, signed sum by unsigned count, truncating toward zero.
// Depends on maf_pkg.
`default_nettype none
module maf_div (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire maf_pkg::div_req_t req,
    output maf_pkg::div_rsp_t      rsp
);

    logic                        busy_reg;
    logic                        done_reg;
    logic                        neg_reg;
    logic [maf_pkg::CNT_W-1:0]   cnt_reg;
    logic [maf_pkg::SUM_W-1:0]   quo_reg;
    logic [maf_pkg::LEN_W-1:0]   rem_reg;
    logic [maf_pkg::LEN_W-1:0]   div_reg;

    logic [maf_pkg::SUM_W-1:0]   mag;
    logic [maf_pkg::LEN_W:0]     rem_sh;
    logic                        ge;
    logic [maf_pkg::LEN_W:0]     rem_sub;
    logic [maf_pkg::SUM_W-1:0]   quo_signed;

    assign mag     = req.dividend[maf_pkg::SUM_W-1] ? maf_pkg::SUM_W'(-req.dividend)
                                                    : maf_pkg::SUM_W'(req.dividend);
    assign rem_sh  = {rem_reg, quo_reg[maf_pkg::SUM_W-1]};
    assign ge      = rem_sh >= {1'b0, div_reg};
    assign rem_sub = rem_sh - {1'b0, div_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == maf_pkg::CNT_W'(maf_pkg::SUM_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            quo_reg <= mag;
            rem_reg <= '0;
            div_reg <= req.divisor;
            neg_reg <= req.dividend[maf_pkg::SUM_W-1];
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[maf_pkg::SUM_W-2:0], ge};
            rem_reg <= ge ? rem_sub[maf_pkg::LEN_W-1:0] : rem_sh[maf_pkg::LEN_W-1:0];
        end
    end

    assign quo_signed   = neg_reg ? (~quo_reg + 1'b1) : quo_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_signed[maf_pkg::SAMPLE_BITS-1:0];

endmodule
`default_nettype wire

>>> rtl/core/moving_average_filter.sv
// Moving average filter top level: ring memory, running sum, APB register, control.
// Depends on maf_pkg, maf_div and moving_average_filter_defines.svh.
//
//   channel   ports                       direction
//   s_        s_op, s_sample              word in  (valid/ready)
//   m_        m_mean, m_window_full       word out (valid/ready)
//   apb       psel..pready                register window_length at 0x0
//
// Sample word: update, 24 divider steps, done, output load, then the next word is taken;
// clear word: output load, then the next word is taken.
// A new word is taken while a result still waits.
// Reset is synchronous, active low; no memory clearing pass is needed.
// A stalled output holds the next result in the divider until the slot frees.
`default_nettype none
`include "moving_average_filter_defines.svh"
module moving_average_filter (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   s_valid,
    output logic                                        s_ready,
    input  wire logic                                   s_op,
    input  wire logic signed [maf_pkg::SAMPLE_BITS-1:0] s_sample,
    output logic                                        m_valid,
    input  wire logic                                   m_ready,
    output logic signed [maf_pkg::SAMPLE_BITS-1:0]      m_mean,
    output logic                                        m_window_full,
    input  wire logic                                   psel,
    input  wire logic                                   penable,
    input  wire logic                                   pwrite,
    input  wire logic [maf_pkg::PADDR_W-1:0]            paddr,
    input  wire logic [maf_pkg::PDATA_W-1:0]            pwdata,
    output logic [maf_pkg::PDATA_W-1:0]                 prdata,
    output logic                                        pready
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_UPD  = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0]                              state_reg, state_next;
    logic [maf_pkg::LEN_W-1:0]               wlen_reg;
    logic [maf_pkg::ADDR_W-1:0]              wpos_reg;
    logic [maf_pkg::LEN_W-1:0]               fill_reg;
    logic signed [maf_pkg::SUM_W-1:0]        sum_reg;
    logic signed [maf_pkg::SAMPLE_BITS-1:0]  sample_reg;
    logic                                    clr_reg;
    logic                                    full_res_reg;
    logic                                    m_valid_reg;
    logic signed [maf_pkg::SAMPLE_BITS-1:0]  m_mean_reg;
    logic                                    m_full_reg;

    logic signed [maf_pkg::SAMPLE_BITS-1:0]  ring_mem [maf_pkg::WINDOW_MAX];
    logic signed [maf_pkg::SAMPLE_BITS-1:0]  rdata_reg;

    logic [maf_pkg::LEN_W-1:0]               eff_len;
    logic                                    s_acc;
    logic                                    cfg_wr;
    logic                                    is_full;
    logic signed [maf_pkg::SUM_W-1:0]        sum_next;
    logic [maf_pkg::LEN_W-1:0]               fill_next;
    logic [maf_pkg::LEN_W-1:0]               wpos_inc;
    logic                                    out_free;
    maf_pkg::div_req_t                       div_req;
    maf_pkg::div_rsp_t                       div_rsp;

    assign eff_len = (wlen_reg == '0) ? maf_pkg::LEN_W'(1)
                   : (wlen_reg > maf_pkg::LEN_MAX) ? maf_pkg::LEN_MAX : wlen_reg;

    assign s_ready  = (state_reg == S_IDLE);
    assign s_acc    = s_valid && s_ready;
    assign cfg_wr   = psel && penable && pwrite
                   && (paddr[maf_pkg::PADDR_W-1:2] == maf_pkg::REG_WINDOW_LENGTH);
    assign out_free = !m_valid_reg || m_ready;

    assign is_full   = (fill_reg == eff_len);
    assign sum_next  = sum_reg + maf_pkg::SUM_W'(sample_reg)
                     - (is_full ? maf_pkg::SUM_W'(rdata_reg) : '0);
    assign fill_next = is_full ? fill_reg : fill_reg + 1'b1;
    assign wpos_inc  = {1'b0, wpos_reg} + 1'b1;

    assign div_req.start    = (state_reg == S_UPD);
    assign div_req.dividend = sum_next;
    assign div_req.divisor  = fill_next;

    maf_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // ring memory, one read port and one write port
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            rdata_reg <= ring_mem[wpos_reg];
        end
        if (state_reg == S_UPD) begin
            ring_mem[wpos_reg] <= sample_reg;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_acc) begin
                    state_next = (s_op == maf_pkg::OP_CLEAR) ? S_OUT : S_UPD;
                end
            end
            S_UPD: state_next = S_DIV;
            S_DIV: begin
                if (div_rsp.done) begin
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            wlen_reg    <= maf_pkg::LEN_RESET;
            wpos_reg    <= '0;
            fill_reg    <= '0;
            sum_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr) begin
                wlen_reg <= pwdata[maf_pkg::LEN_W-1:0];
                wpos_reg <= '0;
                fill_reg <= '0;
                sum_reg  <= '0;
            end else if (s_acc && s_op == maf_pkg::OP_CLEAR) begin
                wpos_reg <= '0;
                fill_reg <= '0;
                sum_reg  <= '0;
            end else if (state_reg == S_UPD) begin
                sum_reg  <= sum_next;
                fill_reg <= fill_next;
                wpos_reg <= (wpos_inc == eff_len) ? '0 : wpos_inc[maf_pkg::ADDR_W-1:0];
            end
            if (state_reg == S_OUT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            sample_reg   <= s_sample;
            clr_reg      <= (s_op == maf_pkg::OP_CLEAR);
            full_res_reg <= 1'b0;
        end else if (state_reg == S_UPD) begin
            full_res_reg <= (fill_next == eff_len);
        end
        if (state_reg == S_OUT && out_free) begin
            m_mean_reg <= clr_reg ? '0 : div_rsp.quotient;
            m_full_reg <= full_res_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_mean        = m_mean_reg;
    assign m_window_full = m_full_reg;

    assign prdata = maf_pkg::PDATA_W'(wlen_reg);
    assign pready = 1'b1;

    `MAF_ASSERT_NOW(a_fill_in_window, aclk, aresetn, 1'b1, fill_reg <= eff_len, "fill count beyond window")
    `MAF_ASSERT_NOW(a_wpos_in_window, aclk, aresetn, 1'b1, {1'b0, wpos_reg} < eff_len, "write position beyond window")
    `MAF_ASSERT_NEXT(a_accept_leaves_idle, aclk, aresetn, s_acc, state_reg != S_IDLE, "accepted word did not start")
    `MAF_ASSERT_NOW(a_div_done_in_div, aclk, aresetn, div_rsp.done, state_reg == S_DIV, "divider finished outside divide state")

endmodule
`default_nettype wire
